// ===== hdl/qrsg_pkg.sv =====
// ----------------------------------------------------------------------------
// qrsg_pkg: shared types and constants of the quadrature sine generator
// Phasor word layout, register indexes and reset coefficients.
// ----------------------------------------------------------------------------
package qrsg_pkg;

  localparam int WORD_W   = 32;
  localparam int SAMPLE_W = 16;
  localparam int PKT_W    = 10;

  // Coefficient reset values, given with 30 fraction bits
  localparam int REF_FRAC_BITS = 30;
  localparam logic signed [WORD_W-1:0] COS_RESET_Q30 = 32'sd848008007;
  localparam logic signed [WORD_W-1:0] SIN_RESET_Q30 = 32'sd658637529;
  localparam logic [PKT_W-1:0]         PKT_LEN_RESET = 10'd89;

  localparam int SAMPLE_SCALE = 32767;

  typedef enum logic [1:0] {
    REG_STEP_COSINE        = 2'd0,
    REG_STEP_SINE          = 2'd1,
    REG_SAMPLES_PER_PACKET = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] x;
    logic signed [WORD_W-1:0] y;
  } phasor_t;

endpackage

// ===== hdl/qrsg_rotate.sv =====
// ----------------------------------------------------------------------------
// qrsg_rotate: phasor rotation and sample scaling
// Rotates (x, y) by the step coefficients and scales y to a 16-bit sample.
// ----------------------------------------------------------------------------
module qrsg_rotate #(
  parameter int FRAC_BITS = 30
) (
  input  qrsg_pkg::phasor_t                     cur,
  input  logic signed [qrsg_pkg::WORD_W-1:0]    step_cos,
  input  logic signed [qrsg_pkg::WORD_W-1:0]    step_sin,
  output qrsg_pkg::phasor_t                     nxt,
  output logic signed [qrsg_pkg::SAMPLE_W-1:0]  sample
);
  import qrsg_pkg::*;

  localparam int PROD_W  = 2 * WORD_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int SCALE_W = WORD_W + SAMPLE_W;

  localparam logic signed [SUM_W-1:0] WORD_MAX =
    (SUM_W'(1) <<< (WORD_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] WORD_MIN = -WORD_MAX - SUM_W'(1);
  localparam logic signed [SCALE_W-1:0] SAMP_MAX = SCALE_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [SCALE_W-1:0] SAMP_MIN = -SAMP_MAX - SCALE_W'(1);
  localparam logic signed [SCALE_W-1:0] SCALE_K  = SCALE_W'(SAMPLE_SCALE);
  localparam logic signed [SCALE_W-1:0] TRUNC_BIAS =
    (SCALE_W'(1) <<< FRAC_BITS) - SCALE_W'(1);

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] q;
    q = v >>> FRAC_BITS;
    if (q > WORD_MAX) begin
      return WORD_MAX[WORD_W-1:0];
    end else if (q < WORD_MIN) begin
      return WORD_MIN[WORD_W-1:0];
    end
    return q[WORD_W-1:0];
  endfunction

  logic signed [PROD_W-1:0]  xc, ys, xs, yc;
  logic signed [SUM_W-1:0]   sum_re, sum_im;
  logic signed [SCALE_W-1:0] scaled, biased, trunc;

  // Signed 32x32 products with full 64-bit results
  assign xc = cur.x * step_cos;
  assign ys = cur.y * step_sin;
  assign xs = cur.x * step_sin;
  assign yc = cur.y * step_cos;

  // Exact sums, then floor shift and clamp
  assign sum_re = SUM_W'(xc) - SUM_W'(ys);
  assign sum_im = SUM_W'(xs) + SUM_W'(yc);
  assign nxt.x  = sat_word(sum_re);
  assign nxt.y  = sat_word(sum_im);

  // Truncate toward zero: bias negative values before the floor shift
  assign scaled = SCALE_W'(cur.y) * SCALE_K;
  assign biased = scaled + (scaled[SCALE_W-1] ? TRUNC_BIAS : '0);
  assign trunc  = biased >>> FRAC_BITS;

  always_comb begin
    if (trunc > SAMP_MAX) begin
      sample = SAMP_MAX[SAMPLE_W-1:0];
    end else if (trunc < SAMP_MIN) begin
      sample = SAMP_MIN[SAMPLE_W-1:0];
    end else begin
      sample = trunc[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== hdl/qrsg_packet.sv =====
// ----------------------------------------------------------------------------
// qrsg_packet: packet fill counter
// Counts samples in the current packet and flags the one that closes it.
// ----------------------------------------------------------------------------
module qrsg_packet (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [qrsg_pkg::PKT_W-1:0] pkt_len,
  output logic                       last
);
  import qrsg_pkg::*;

  logic [PKT_W-1:0] fill;
  logic [PKT_W-1:0] fill_inc;

  // Wrap to zero also closes the packet
  assign fill_inc = fill + PKT_W'(1);
  assign last     = (fill_inc >= pkt_len) || (fill_inc == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (step) begin
      fill <= last ? '0 : fill_inc;
    end
  end

endmodule

// ===== hdl/quadrature_rotation_sine_generator.sv =====
// ----------------------------------------------------------------------------
// quadrature_rotation_sine_generator: coupled-form sine oscillator
// Rotates a stored phasor by a programmable step each tick, emits the scaled
// imaginary part as a 16-bit sample and marks the last sample of each packet.
// ----------------------------------------------------------------------------
// Path: stage register holds the tick, output register holds its sample.
// Throughput: one item per cycle while out_stall is low; the phasor update
//   (four 32x32 products, two sums, clamp) lands as the stage hands over.
// Items with advance low are taken and dropped, they give no sample.
// Reset: phasor to 1.0 + 0j, packet count to zero, coefficients and packet
//   length to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module quadrature_rotation_sine_generator #(
  parameter int FRAC_BITS = 30
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 wr_en,
  input  logic [1:0]                           wr_index,
  input  logic [qrsg_pkg::WORD_W-1:0]          wr_data,
  // tick channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 advance,
  // sample channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [qrsg_pkg::SAMPLE_W-1:0] sample,
  output logic                                 packet_last
);
  import qrsg_pkg::*;

  localparam logic signed [WORD_W-1:0] COS_RESET =
    COS_RESET_Q30 >>> (REF_FRAC_BITS - FRAC_BITS);
  localparam logic signed [WORD_W-1:0] SIN_RESET =
    SIN_RESET_Q30 >>> (REF_FRAC_BITS - FRAC_BITS);
  localparam logic signed [WORD_W-1:0] ONE = WORD_W'(64'sd1 <<< FRAC_BITS);

  // Configuration registers
  logic signed [WORD_W-1:0] step_cosine;
  logic signed [WORD_W-1:0] step_sine;
  logic [PKT_W-1:0]         samples_per_packet;

  // Stage register: holds one pending tick
  logic stage_valid;
  logic stage_move;
  logic in_take;

  // Oscillator state
  phasor_t                     phasor;
  phasor_t                     phasor_next;
  logic signed [SAMPLE_W-1:0]  sample_next;
  logic                        last_next;

  // Hand over whenever the output register is free or being drained
  assign stage_move = stage_valid && (!out_valid || !out_stall);
  assign in_stall   = stage_valid && !stage_move;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cosine        <= COS_RESET;
      step_sine          <= SIN_RESET;
      samples_per_packet <= PKT_LEN_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_STEP_COSINE:        step_cosine        <= wr_data;
        REG_STEP_SINE:          step_sine          <= wr_data;
        REG_SAMPLES_PER_PACKET: samples_per_packet <= wr_data[PKT_W-1:0];
        default: ;
      endcase
    end
  end

  // Keep only ticks that ask for a sample; drop idle ones at the door
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_take) begin
      stage_valid <= advance;
    end else if (stage_move) begin
      stage_valid <= 1'b0;
    end
  end

  qrsg_rotate #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rotate (
    .cur      (phasor),
    .step_cos (step_cosine),
    .step_sin (step_sine),
    .nxt      (phasor_next),
    .sample   (sample_next)
  );

  qrsg_packet u_packet (
    .clk     (clk),
    .rst     (rst),
    .step    (stage_move),
    .pkt_len (samples_per_packet),
    .last    (last_next)
  );

  // Advance the phasor once per emitted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      phasor.x <= ONE;
      phasor.y <= '0;
    end else if (stage_move) begin
      phasor <= phasor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sample is taken from the phasor before rotation
  always_ff @(posedge clk) begin
    if (stage_move) begin
      sample      <= sample_next;
      packet_last <= last_next;
    end
  end

  // Phasor changes only when a sample is emitted
  a_phasor_hold: assert property (@(posedge clk) disable iff (rst)
    !stage_move |=> $stable(phasor))
    else $error("phasor changed without an emitted sample");

  // Back-pressure only when the output is full and held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (stage_valid && out_valid && out_stall))
    else $error("input stalled without a held output");

  // A handed-over tick always shows up as a valid sample
  a_move_shows: assert property (@(posedge clk) disable iff (rst)
    stage_move |=> out_valid)
    else $error("handed-over tick produced no sample");

endmodule

// ===== sim/sine_sample_checker.sv =====
// ----------------------------------------------------------------------------
// sine_sample_checker: predicts and checks the sine generator's samples
// Watches register writes, accepted ticks and accepted samples. Keeps its own
// phasor, coefficients and packet count, queues the sample owed for each tick
// and compares every sample that leaves the block with the oldest one owed.
// ----------------------------------------------------------------------------
module sine_sample_checker #(
  parameter int FRAC_BITS = 30
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [1:0]                           wr_index,
  input  logic [qrsg_pkg::WORD_W-1:0]          wr_data,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 advance,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [qrsg_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 packet_last,
  output int                                   mismatch_count,
  output int                                   samples_owed
);
  import qrsg_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } tone_item_t;

  tone_item_t                owed_q[$];
  logic signed [WORD_W-1:0]  step_cos;
  logic signed [WORD_W-1:0]  step_sin;
  logic [PKT_W-1:0]          pkt_len;
  logic signed [WORD_W-1:0]  phasor_re;
  logic signed [WORD_W-1:0]  phasor_im;
  logic [PKT_W-1:0]          pkt_fill;

  initial begin
    mismatch_count = 0;
    samples_owed   = 0;
  end

  // floor((a*b +/- d*e) / 2^FRAC_BITS), clamped to the 32-bit signed range
  function automatic logic signed [WORD_W-1:0] rotate_axis(
    input logic signed [WORD_W-1:0] a,
    input logic signed [WORD_W-1:0] b,
    input logic signed [WORD_W-1:0] d,
    input logic signed [WORD_W-1:0] e,
    input logic                     negate
  );
    logic signed [65:0] ab;
    logic signed [65:0] de;
    logic signed [65:0] acc;
    ab  = a;
    ab  = ab * b;
    de  = d;
    de  = de * e;
    acc = negate ? ab - de : ab + de;
    acc = acc >>> FRAC_BITS;
    if (acc > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (acc < -66'sd2147483648) return 32'sh8000_0000;
    return acc[WORD_W-1:0];
  endfunction

  // 32767 * y, truncated toward zero, clamped to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] scale_sample(
    input logic signed [WORD_W-1:0] y
  );
    logic signed [63:0] p;
    logic signed [63:0] t;
    p = y;
    p = p * SAMPLE_SCALE;
    t = (p < 0) ? -((-p) >>> FRAC_BITS) : (p >>> FRAC_BITS);
    if (t > 64'sd32767) t = 64'sd32767;
    if (t < -64'sd32768) t = -64'sd32768;
    return t[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    tone_item_t               want;
    logic signed [WORD_W-1:0] next_re;
    logic [PKT_W-1:0]         next_fill;
    if (rst) begin
      step_cos  = COS_RESET_Q30 >>> (REF_FRAC_BITS - FRAC_BITS);
      step_sin  = SIN_RESET_Q30 >>> (REF_FRAC_BITS - FRAC_BITS);
      pkt_len   = PKT_LEN_RESET;
      phasor_re = 32'sd1 <<< FRAC_BITS;
      phasor_im = '0;
      pkt_fill  = '0;
      owed_q.delete();
    end else begin
      // compare first: a sample leaving now never belongs to a tick taken now
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected sample %0d last %0b", $realtime, sample,
                     packet_last);
        end else begin
          want = owed_q.pop_front();
          if (sample !== want.sample || packet_last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: sample %0d last %0b, expected %0d last %0b",
                       $realtime, sample, packet_last, want.sample, want.last);
          end
        end
      end
      if (wr_en) begin
        case (reg_index_t'(wr_index))
          REG_STEP_COSINE:        step_cos = wr_data;
          REG_STEP_SINE:          step_sin = wr_data;
          REG_SAMPLES_PER_PACKET: pkt_len  = wr_data[PKT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall && advance) begin
        want.sample = scale_sample(phasor_im);
        next_re   = rotate_axis(phasor_re, step_cos, phasor_im, step_sin, 1'b1);
        phasor_im = rotate_axis(phasor_re, step_sin, phasor_im, step_cos, 1'b0);
        phasor_re = next_re;
        // a zero length acts as one; wrap of the count also closes a packet
        next_fill = pkt_fill + 1'b1;
        want.last = (next_fill >= pkt_len) || (next_fill == '0);
        pkt_fill  = want.last ? '0 : next_fill;
        owed_q.insert(owed_q.size(), want);
      end
    end
    samples_owed = owed_q.size();
  end

endmodule

// ===== sim/tb_quadrature_rotation_sine_generator.sv =====
// ----------------------------------------------------------------------------
// tb_quadrature_rotation_sine_generator: testbench of the sine generator
// Drives ticks and register writes, stalls the sample side at random and
// leaves prediction and comparison to the sample checker beside the block.
// ----------------------------------------------------------------------------
module tb_quadrature_rotation_sine_generator;
  import qrsg_pkg::*;

  localparam int FRAC_BITS    = 30;
  localparam int LIMIT_CYCLES = 200000;
  // Settle time after the last owed sample has left the block.
  localparam int DRAIN_CYCLES = 4;

  localparam logic signed [WORD_W-1:0] Q30_ONE      = 32'sh4000_0000;
  localparam logic [1:0]               REG_UNMAPPED = 2'd3;

  logic                        clk;
  logic                        rst;
  logic                        wr_en;
  logic [1:0]                  wr_index;
  logic [WORD_W-1:0]           wr_data;
  logic                        in_valid;
  logic                        in_stall;
  logic                        advance;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [SAMPLE_W-1:0]  sample;
  logic                        packet_last;

  int mismatch_count;
  int samples_owed;
  int cycle_count = 0;
  int send_idle_pct;
  int stall_pct;

  quadrature_rotation_sine_generator #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample     (sample),
    .packet_last(packet_last)
  );

  sine_sample_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) sample_check (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample        (sample),
    .packet_last   (packet_last),
    .mismatch_count(mismatch_count),
    .samples_owed  (samples_owed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: stall at random with the current percentage
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[quadrature_rotation_sine_generator] ERROR");
      $finish;
    end
  end

  // Offer one tick; hold it until the block takes it. Random idle cycles go
  // ahead of it, with valid low and the payload free to wander.
  task automatic send_tick(input logic adv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      advance  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    advance  <= adv;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait until every owed sample has left, then wait out the
  // drain time before the caller writes a register.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (samples_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register; the caller lowers the write enable after the group
  task automatic write_reg(input logic [1:0] idx, input logic [WORD_W-1:0] value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
  endtask

  function automatic logic signed [WORD_W-1:0] edge_coeff();
    case ($urandom_range(2))
      0:       return Q30_ONE;
      1:       return -Q30_ONE;
      default: return '0;
    endcase
  endfunction

  // Pick a new step, usually written, and maybe a new packet length. Mostly true rotations,
  // the rest bounded noise, range edges, raw patterns and a growth step
  // that pulls a decayed phasor back up.
  task automatic retune();
    real                      theta;
    logic signed [WORD_W-1:0] c;
    logic signed [WORD_W-1:0] s;
    logic [PKT_W-1:0]         len;
    int                       pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      theta = $urandom * 6.283185307179586 / 4294967296.0;
      c = $rtoi($cos(theta) * 1073741824.0);
      s = $rtoi($sin(theta) * 1073741824.0);
    end else if (pick < 67) begin
      c = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      s = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    end else if (pick < 79) begin
      c = edge_coeff();
      s = edge_coeff();
    end else if (pick < 90) begin
      c = $urandom;
      s = $urandom;
    end else begin
      c = Q30_ONE;
      s = Q30_ONE;
    end
    // a zero step would pin the phasor at the origin for good
    if (c == '0 && s == '0) c = Q30_ONE;
    if ($urandom_range(99) < 80) begin
      write_reg(REG_STEP_COSINE, c);
      write_reg(REG_STEP_SINE, s);
    end
    if ($urandom_range(99) < 65) begin
      pick = $urandom_range(99);
      if (pick < 60)      len = PKT_W'($urandom_range(1, 16));
      else if (pick < 75) len = PKT_W'($urandom_range(17, 200));
      else if (pick < 80) len = 10'd1000;
      else if (pick < 85) len = 10'd1023;
      else if (pick < 90) len = '0;
      else                len = 10'd1;
      // upper data bits are junk the block must ignore
      write_reg(REG_SAMPLES_PER_PACKET, {22'($urandom), len});
    end
    wr_en <= 1'b0;
  endtask

  initial begin
    int ticks_left;
    int seg_len;
    logic adv;

    rst           <= 1'b1;
    wr_en         <= 1'b0;
    wr_index      <= '0;
    wr_data       <= '0;
    in_valid      <= 1'b0;
    advance       <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: first samples of the default step, with dropped ticks
    // mixed in to show they leave the phasor alone.
    repeat (4) send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    settle();

    // Unmapped index must change nothing; zero length marks every sample last
    write_reg(REG_UNMAPPED, $urandom);
    write_reg(REG_SAMPLES_PER_PACKET, {22'h3F_FFFF, 10'd0});
    wr_en <= 1'b0;
    repeat (3) send_tick(1'b1);
    settle();

    // Shorten the packet mid-way: count is past the new length, so the next
    // sample closes the packet.
    write_reg(REG_SAMPLES_PER_PACKET, 32'd5);
    wr_en <= 1'b0;
    repeat (3) send_tick(1'b1);
    settle();
    write_reg(REG_SAMPLES_PER_PACKET, 32'd2);
    wr_en <= 1'b0;
    repeat (2) send_tick(1'b1);
    settle();

    // Out-of-range steps: drive the phasor into positive then negative
    // saturation so both sample clamps show up.
    write_reg(REG_STEP_COSINE, 32'h7FFF_FFFF);
    write_reg(REG_STEP_SINE, 32'h7FFF_FFFF);
    write_reg(REG_SAMPLES_PER_PACKET, 32'd1000);
    wr_en <= 1'b0;
    repeat (2) send_tick(1'b1);
    settle();
    write_reg(REG_STEP_COSINE, 32'h8000_0000);
    write_reg(REG_STEP_SINE, 32'h8000_0000);
    wr_en <= 1'b0;
    repeat (2) send_tick(1'b1);
    settle();
    write_reg(REG_STEP_COSINE, Q30_ONE);
    write_reg(REG_STEP_SINE, -Q30_ONE);
    wr_en <= 1'b0;
    repeat (2) send_tick(1'b1);

    // Random part in three idling phases: slow receiver, slow sender, none.
    // Each phase runs segments of ticks under a fresh setting.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 13;
          stall_pct     = 87;
        end
        1: begin
          send_idle_pct = 87;
          stall_pct     = 13;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      ticks_left = 433;
      while (ticks_left > 0) begin
        settle();
        retune();
        seg_len = $urandom_range(10, 90);
        for (int i = 0; i < seg_len && ticks_left > 0; i++) begin
          adv = ($urandom_range(99) < 80);
          send_tick(adv);
          ticks_left--;
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[quadrature_rotation_sine_generator] OK");
    end else begin
      $display("[quadrature_rotation_sine_generator] ERROR");
    end
    $finish;
  end

endmodule
